>>> rtl/sse_pkg.sv
// Shared types and codes for the sortable stack engine.
package sse_pkg;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_FIND = 2'd2,
    OP_SORT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_FIND,
    S_SORT_SCAN,
    S_SORT_SWAP,
    S_RESP
  } state_e;

  localparam int unsigned ValueW  = 16;
  localparam int unsigned PosW    = 6;
  localparam int unsigned StatusW = 2;

endpackage

>>> rtl/sortable_stack_engine.sv
// Sortable stack engine: bounded signed stack in RAM with find and in-place sort.
//
// Input channel (in_valid_i/in_ready_o) takes one request: operation_i and
// value_i. Output channel (out_valid_o/out_ready_i) returns one result per
// request: result_value_o, position_o and status_o. Requests are handled one
// at a time; in_ready_o is high whenever the engine is idle, even while the
// previous result still waits in the output register.
// After acceptance (n = entries held): push and a sort of fewer than two
//   entries go straight to the response stage, pop reads the top entry, find
//   compares k entries from the top (k at most n), and a larger sort makes
//   one RAM read per cycle, broken only by swaps (at most n-1): each pass
//   scans the unsorted part and a swap adds a write state.
// The state RAM has one read and one write port with registered read data;
// the scan loops are set by that single read port.
// Reset empties the stack (entry count to zero) and drops any pending result;
// the RAM contents are not cleared. If the receiver stalls, the result holds
// in the output register; a finished request waits in its final stage until
// the register frees up, and no new request is taken meanwhile.
module sortable_stack_engine
  import sse_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               operation_i,
  input  logic signed [ValueW-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [ValueW-1:0] result_value_o,
  output logic [PosW-1:0]          position_o,
  output logic [StatusW-1:0]       status_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [AW-1:0] top_q, top_d;
  logic first_q, first_d;
  logic [DATA_WIDTH-1:0] best_val_q, best_val_d;
  logic [AW-1:0] best_addr_q, best_addr_d;
  logic [DATA_WIDTH-1:0] top_val_q, top_val_d;

  logic [ValueW-1:0] res_value_q, res_value_d;
  logic [PosW-1:0] res_pos_q, res_pos_d;
  status_e res_status_q, res_status_d;

  logic out_valid_q, out_valid_d;
  logic [ValueW-1:0] out_value_q, out_value_d;
  logic [PosW-1:0] out_pos_q, out_pos_d;
  logic [StatusW-1:0] out_status_q, out_status_d;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic in_accept;
  logic [DATA_WIDTH-1:0] in_val;
  logic [AW-1:0] count_top;
  logic [CW-1:0] find_dist;
  logic scan_better;
  logic [DATA_WIDTH-1:0] scan_best_val;
  logic [AW-1:0] scan_best_addr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign in_val     = DATA_WIDTH'(value_i);
  assign count_top  = AW'(count_q - 1'b1);
  assign find_dist  = count_q - 1'b1 - CW'(cur_q);

  // running maximum including the entry arriving this cycle
  assign scan_better = $signed(mem_rdata) > $signed(best_val_q);
  always_comb begin
    if (first_q || scan_better) begin
      scan_best_val  = mem_rdata;
      scan_best_addr = cur_q;
    end else begin
      scan_best_val  = best_val_q;
      scan_best_addr = best_addr_q;
    end
  end

  sse_ram #(
    .Width (DATA_WIDTH),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    val_d        = val_q;
    cur_d        = cur_q;
    top_d        = top_q;
    first_d      = first_q;
    best_val_d   = best_val_q;
    best_addr_d  = best_addr_q;
    top_val_d    = top_val_q;
    res_value_d  = res_value_q;
    res_pos_d    = res_pos_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_value_d  = out_value_q;
    out_pos_d    = out_pos_q;
    out_status_d = out_status_q;
    mem_we       = 1'b0;
    mem_waddr    = count_q[AW-1:0];
    mem_wdata    = in_val;
    mem_raddr    = count_top;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          val_d        = in_val;
          res_value_d  = '0;
          res_pos_d    = '0;
          res_status_d = ST_OK;
          state_d      = S_RESP;
          case (op_e'(operation_i))
            OP_PUSH: begin
              if (count_q == CW'(DEPTH)) begin
                res_status_d = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = count_q[AW-1:0];
                count_d   = count_q + 1'b1;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                count_d = count_q - 1'b1;
                state_d = S_POP_RD;
              end
            end
            OP_FIND: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
              end else begin
                cur_d   = count_top;
                state_d = S_FIND;
              end
            end
            OP_SORT: begin
              if (count_q > CW'(1)) begin
                top_d   = count_top;
                cur_d   = count_top;
                first_d = 1'b1;
                state_d = S_SORT_SCAN;
              end
            end
            default: ;
          endcase
        end
      end

      S_POP_RD: begin
        res_value_d = ValueW'($signed(mem_rdata));
        state_d     = S_RESP;
      end

      S_FIND: begin
        if (mem_rdata == val_q) begin
          res_pos_d = PosW'(find_dist);
          state_d   = S_RESP;
        end else if (cur_q == '0) begin
          res_status_d = ST_NOT_FOUND;
          state_d      = S_RESP;
        end else begin
          cur_d     = cur_q - 1'b1;
          mem_raddr = cur_q - 1'b1;
        end
      end

      S_SORT_SCAN: begin
        best_val_d  = scan_best_val;
        best_addr_d = scan_best_addr;
        first_d     = 1'b0;
        if (first_q) begin
          top_val_d = mem_rdata;
        end
        if (cur_q != '0) begin
          cur_d     = cur_q - 1'b1;
          mem_raddr = cur_q - 1'b1;
        end else if (scan_best_addr != top_q) begin
          // largest goes to the top of the unsorted part now, old top next cycle
          mem_we    = 1'b1;
          mem_waddr = top_q;
          mem_wdata = scan_best_val;
          state_d   = S_SORT_SWAP;
        end else if (top_q == AW'(1)) begin
          state_d = S_RESP;
        end else begin
          top_d     = top_q - 1'b1;
          cur_d     = top_q - 1'b1;
          mem_raddr = top_q - 1'b1;
          first_d   = 1'b1;
        end
      end

      S_SORT_SWAP: begin
        mem_we    = 1'b1;
        mem_waddr = best_addr_q;
        mem_wdata = top_val_q;
        if (top_q == AW'(1)) begin
          state_d = S_RESP;
        end else begin
          top_d     = top_q - 1'b1;
          cur_d     = top_q - 1'b1;
          mem_raddr = top_q - 1'b1;
          first_d   = 1'b1;
          state_d   = S_SORT_SCAN;
        end
      end

      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_value_d  = res_value_q;
          out_pos_d    = res_pos_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q        <= val_d;
    cur_q        <= cur_d;
    top_q        <= top_d;
    best_val_q   <= best_val_d;
    best_addr_q  <= best_addr_d;
    top_val_q    <= top_val_d;
    res_value_q  <= res_value_d;
    res_pos_q    <= res_pos_d;
    res_status_q <= res_status_d;
    out_value_q  <= out_value_d;
    out_pos_q    <= out_pos_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign position_o     = out_pos_q;
  assign status_o       = out_status_q;

  // the entry count never passes the stack depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // RAM writes only come from a push or from a sort swap
  a_write_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_IDLE || state_q == S_SORT_SCAN || state_q == S_SORT_SWAP))
    else $error("unexpected RAM write");

  // a push on a non-full stack grows it by one
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && operation_i == OP_PUSH && count_q != CW'(DEPTH))
      |=> count_q == $past(count_q) + 1'b1)
    else $error("push did not advance entry count");

  // the find scan stays inside the filled part of the stack
  a_find_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND) |-> (CW'(cur_q) < count_q))
    else $error("find scan outside stack");

  // entry count holds during a sort
  a_sort_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SORT_SCAN || state_q == S_SORT_SWAP) |=> $stable(count_q))
    else $error("entry count changed during sort");

endmodule

>>> rtl/sse_ram.sv
// Generic single-write, single-read RAM with registered, write-first read data.
module sse_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // same-address write is forwarded to the read port
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_o <= wdata_i;
    end else begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
